### rtl/i2c_register_read_sequencer_assert.svh
// assertion macros for the i2c register read sequencer
// used by the checker module; needs no package
`ifndef I2C_REGISTER_READ_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_READ_SEQUENCER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define IRRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("irrs assertion failed");

// next-cycle implication under synchronous active-low reset
`define IRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("irrs assertion failed");

`endif

### rtl/irrs_pkg.sv
// types and constants of the i2c register read sequencer
// no dependencies
`default_nettype none

package irrs_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    localparam logic [7:0] ST_MASK       = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;

    localparam logic DIR_WRITE = 1'b0;
    localparam logic DIR_READ  = 1'b1;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_START  = 3'd1;
    localparam logic [2:0] ERR_ADDR_W = 3'd2;
    localparam logic [2:0] ERR_REG    = 3'd3;
    localparam logic [2:0] ERR_RSTART = 3'd4;
    localparam logic [2:0] ERR_ADDR_R = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_ADDRW  = 3'd2,
        PH_REG    = 3'd3,
        PH_RSTART = 3'd4,
        PH_ADDRR  = 3'd5,
        PH_RECV   = 3'd6
    } t_phase;

    typedef struct packed {
        logic       mode;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } t_req;

    typedef struct packed {
        logic       issue_start;
        logic       issue_stop;
        logic       issue_receive;
        logic       ack_receive;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic [2:0] error_code;
        logic       busy_reject;
    } t_rsp;

    // handshake between top level and sequencer core
    typedef struct packed {
        logic       advance;
        logic [6:0] dev_addr;
    } t_seq_ctrl;

endpackage

`default_nettype wire

### rtl/irrs_if.sv
// valid/ready channel interfaces for request and response transactions
// depends on irrs_pkg
`default_nettype none

interface irrs_req_if;
    logic            valid;
    logic            ready;
    irrs_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface irrs_rsp_if;
    logic            valid;
    logic            ready;
    irrs_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/irrs_apb_regs.sv
// apb configuration register: seven-bit device address
// depends on irrs_pkg
`default_nettype none

module irrs_apb_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [irrs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [irrs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [irrs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output logic      [6:0]                          o_dev_addr
);

    logic [6:0] r_dev_addr;
    logic       w_sel_dev;

    assign w_sel_dev = (paddr[irrs_pkg::APB_ADDR_W-1] == irrs_pkg::REG_DEVICE_ADDRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= irrs_pkg::DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && w_sel_dev) begin
            r_dev_addr <= pwdata[6:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_dev) begin
            prdata = {{(irrs_pkg::APB_DATA_W-7){1'b0}}, r_dev_addr};
        end
    end

    assign pready     = 1'b1;
    assign o_dev_addr = r_dev_addr;

endmodule

`default_nettype wire

### rtl/irrs_seq.sv
// burst read phase sequencer: phase state and per-transaction result logic
// depends on irrs_pkg
`default_nettype none

module irrs_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire irrs_pkg::t_seq_ctrl  i_ctrl,
    input  wire irrs_pkg::t_req       i_item,
    output irrs_pkg::t_rsp            o_rsp
);

    irrs_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_target, n_target;
    logic [7:0]       r_remaining, n_remaining;
    logic [7:0]       w_st;
    logic [7:0]       w_rem_dec;
    logic             w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= irrs_pkg::PH_IDLE;
            r_target    <= '0;
            r_remaining <= '0;
        end else if (i_ctrl.advance) begin
            r_phase     <= n_phase;
            r_target    <= n_target;
            r_remaining <= n_remaining;
        end
    end

    assign w_st      = i_item.bus_status & irrs_pkg::ST_MASK;
    assign w_rem_dec = r_remaining - 8'd1;
    assign w_idle    = (r_phase == irrs_pkg::PH_IDLE) || (r_phase == 3'd7);

    always_comb begin
        n_phase     = r_phase;
        n_target    = r_target;
        n_remaining = r_remaining;
        o_rsp       = '0;
        if (i_item.mode == irrs_pkg::MODE_START) begin
            if (!w_idle) begin
                o_rsp.busy_reject = 1'b1;
            end else begin
                n_target          = i_item.register_address;
                n_remaining       = (i_item.byte_count == 8'd0) ? 8'd1 : i_item.byte_count;
                n_phase           = irrs_pkg::PH_START;
                o_rsp.issue_start = 1'b1;
            end
        end else begin
            unique case (r_phase)
                irrs_pkg::PH_START: begin
                    if (w_st != irrs_pkg::ST_START) begin
                        o_rsp.issue_stop = 1'b1;
                        o_rsp.error_code = irrs_pkg::ERR_START;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        o_rsp.send_valid = 1'b1;
                        o_rsp.send_byte  = {i_ctrl.dev_addr, irrs_pkg::DIR_WRITE};
                        n_phase          = irrs_pkg::PH_ADDRW;
                    end
                end
                irrs_pkg::PH_ADDRW: begin
                    if (w_st != irrs_pkg::ST_SLA_W_ACK) begin
                        o_rsp.issue_stop = 1'b1;
                        o_rsp.error_code = irrs_pkg::ERR_ADDR_W;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        o_rsp.send_valid = 1'b1;
                        o_rsp.send_byte  = r_target;
                        n_phase          = irrs_pkg::PH_REG;
                    end
                end
                irrs_pkg::PH_REG: begin
                    if (w_st != irrs_pkg::ST_DATA_W_ACK) begin
                        o_rsp.issue_stop = 1'b1;
                        o_rsp.error_code = irrs_pkg::ERR_REG;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        o_rsp.issue_start = 1'b1;
                        n_phase           = irrs_pkg::PH_RSTART;
                    end
                end
                irrs_pkg::PH_RSTART: begin
                    if (w_st != irrs_pkg::ST_REP_START) begin
                        o_rsp.issue_stop = 1'b1;
                        o_rsp.error_code = irrs_pkg::ERR_RSTART;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        o_rsp.send_valid = 1'b1;
                        o_rsp.send_byte  = {i_ctrl.dev_addr, irrs_pkg::DIR_READ};
                        n_phase          = irrs_pkg::PH_ADDRR;
                    end
                end
                irrs_pkg::PH_ADDRR: begin
                    if (w_st != irrs_pkg::ST_SLA_R_ACK) begin
                        o_rsp.issue_stop = 1'b1;
                        o_rsp.error_code = irrs_pkg::ERR_ADDR_R;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        n_remaining         = w_rem_dec;
                        o_rsp.issue_receive = 1'b1;
                        o_rsp.ack_receive   = (w_rem_dec != 8'd0);
                        n_phase             = irrs_pkg::PH_RECV;
                    end
                end
                irrs_pkg::PH_RECV: begin
                    o_rsp.read_valid = 1'b1;
                    o_rsp.read_byte  = i_item.received_byte;
                    if (r_remaining == 8'd0) begin
                        o_rsp.read_last  = 1'b1;
                        o_rsp.issue_stop = 1'b1;
                        n_phase          = irrs_pkg::PH_IDLE;
                    end else begin
                        n_remaining         = w_rem_dec;
                        o_rsp.issue_receive = 1'b1;
                        o_rsp.ack_receive   = (w_rem_dec != 8'd0);
                    end
                end
                default: begin
                    // completion with no transaction running
                    n_phase = irrs_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/i2c_register_read_sequencer.sv
// top level of the i2c register burst read sequencer
// depends on irrs_pkg, irrs_if, irrs_apb_regs, irrs_seq
//
//   channel  | dir | handshake         | contents
//   ---------+-----+-------------------+------------------------------------
//   i_req    | in  | valid/ready       | start request or engine completion
//   o_rsp    | out | valid/ready       | engine command, read byte, status
//   apb      | in  | psel/penable      | device address register
//
// one transaction per cycle unless o_rsp stalls; its result is registered on o_rsp
// a stall on o_rsp holds the result register; a second transaction waits in the
// input register and i_req.ready stays low until o_rsp.ready returns
// synchronous active-low reset clears phase, counters and both valid flags
`default_nettype none

module i2c_register_read_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    irrs_req_if.sink                               i_req,
    irrs_rsp_if.source                             o_rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [irrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [irrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [irrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    logic                r_in_valid;
    irrs_pkg::t_req      r_in;
    logic                r_out_valid;
    irrs_pkg::t_rsp      r_out;
    irrs_pkg::t_rsp      w_rsp;
    irrs_pkg::t_seq_ctrl w_ctrl;
    logic [6:0]          w_dev_addr;
    logic                w_adv;
    logic                w_in_ready;

    irrs_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_dev_addr (w_dev_addr)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_in_ready = !r_in_valid || w_adv;

    assign w_ctrl.advance  = w_adv;
    assign w_ctrl.dev_addr = w_dev_addr;

    irrs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_item  (r_in),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && w_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_in_ready) begin
            r_in <= i_req.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_rsp;
        end
    end

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

`default_nettype wire

### rtl/irrs_checker.sv
// port-level checker for the i2c register read sequencer, bound to the top level
// depends on irrs_pkg and i2c_register_read_sequencer_assert.svh
`default_nettype none

`include "i2c_register_read_sequencer_assert.svh"

module irrs_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_rsp_valid,
    input wire logic            i_rsp_ready,
    input wire irrs_pkg::t_rsp  i_rsp
);

    `IRRS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp))
    `IRRS_ASSERT_IMP(a_rst_clears_valid, i_clk, i_rst_n, $rose(i_rst_n), !i_rsp_valid)
    `IRRS_ASSERT_IMP(a_error_stops, i_clk, i_rst_n, i_rsp_valid && (i_rsp.error_code != irrs_pkg::ERR_NONE), i_rsp.issue_stop && !i_rsp.send_valid && !i_rsp.read_valid)
    `IRRS_ASSERT_IMP(a_last_stops, i_clk, i_rst_n, i_rsp_valid && i_rsp.read_last, i_rsp.read_valid && i_rsp.issue_stop && !i_rsp.issue_receive)

endmodule

bind i2c_register_read_sequencer irrs_checker u_irrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

`default_nettype wire

### verif/i2c_register_read_sequencer_tb.sv
// testbench of the i2c register burst read sequencer: directed table, then random burst reads
// each response transaction is checked against an in-bench sequencer predictor, or for a typed
// table row against that row's expected response; depends on irrs_pkg, irrs_if and i2c_register_read_sequencer
`default_nettype none

module i2c_register_read_sequencer_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SEGMENT_ITEMS = 340;
    localparam int unsigned ADDR_W = irrs_pkg::APB_ADDR_W;
    localparam int unsigned DATA_W = irrs_pkg::APB_DATA_W;
    localparam logic [ADDR_W-1:0] DEV_ADDR_OFFSET =
        ADDR_W'(4 * int'(irrs_pkg::REG_DEVICE_ADDRESS));

    typedef struct {
        irrs_pkg::t_req req;
        bit             typed;
        irrs_pkg::t_rsp want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    irrs_req_if req_if ();
    irrs_rsp_if rsp_if ();

    i2c_register_read_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    irrs_pkg::t_phase cur_phase;
    logic [7:0]       first_reg;
    logic [7:0]       bytes_left;
    logic [6:0]       dev_addr;

    irrs_pkg::t_rsp pending_responses[$];
    int unsigned    error_count;
    int unsigned    cycle_count;
    int unsigned    items_sent;
    bit             no_gaps;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100) begin
            $display("mismatch %s: got 0x%0h, expected 0x%0h at cycle %0d",
                     what, got, want, cycle_count);
        end
        error_count++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic [7:0] phase_status(input irrs_pkg::t_phase p);
        case (p)
            irrs_pkg::PH_START:  return irrs_pkg::ST_START;
            irrs_pkg::PH_ADDRW:  return irrs_pkg::ST_SLA_W_ACK;
            irrs_pkg::PH_REG:    return irrs_pkg::ST_DATA_W_ACK;
            irrs_pkg::PH_RSTART: return irrs_pkg::ST_REP_START;
            default:             return irrs_pkg::ST_SLA_R_ACK;
        endcase
    endfunction

    function automatic irrs_pkg::t_rsp sequencer_step(input irrs_pkg::t_req r);
        irrs_pkg::t_rsp o;
        logic [7:0] st;
        o = '0;
        st = r.bus_status & irrs_pkg::ST_MASK;
        if (r.mode == irrs_pkg::MODE_START) begin
            if (cur_phase == irrs_pkg::PH_IDLE) begin
                first_reg = r.register_address;
                bytes_left = (r.byte_count == 8'd0) ? 8'd1 : r.byte_count;
                cur_phase = irrs_pkg::PH_START;
                o.issue_start = 1'b1;
            end else begin
                o.busy_reject = 1'b1;
            end
            return o;
        end
        if (cur_phase != irrs_pkg::PH_IDLE && cur_phase != irrs_pkg::PH_RECV &&
            st != phase_status(cur_phase)) begin
            o.issue_stop = 1'b1;
            case (cur_phase)
                irrs_pkg::PH_START:  o.error_code = irrs_pkg::ERR_START;
                irrs_pkg::PH_ADDRW:  o.error_code = irrs_pkg::ERR_ADDR_W;
                irrs_pkg::PH_REG:    o.error_code = irrs_pkg::ERR_REG;
                irrs_pkg::PH_RSTART: o.error_code = irrs_pkg::ERR_RSTART;
                default:             o.error_code = irrs_pkg::ERR_ADDR_R;
            endcase
            cur_phase = irrs_pkg::PH_IDLE;
            return o;
        end
        case (cur_phase)
            irrs_pkg::PH_START: begin
                o.send_valid = 1'b1;
                o.send_byte = {dev_addr, irrs_pkg::DIR_WRITE};
                cur_phase = irrs_pkg::PH_ADDRW;
            end
            irrs_pkg::PH_ADDRW: begin
                o.send_valid = 1'b1;
                o.send_byte = first_reg;
                cur_phase = irrs_pkg::PH_REG;
            end
            irrs_pkg::PH_REG: begin
                o.issue_start = 1'b1;
                cur_phase = irrs_pkg::PH_RSTART;
            end
            irrs_pkg::PH_RSTART: begin
                o.send_valid = 1'b1;
                o.send_byte = {dev_addr, irrs_pkg::DIR_READ};
                cur_phase = irrs_pkg::PH_ADDRR;
            end
            irrs_pkg::PH_ADDRR, irrs_pkg::PH_RECV: begin
                if (cur_phase == irrs_pkg::PH_RECV) begin
                    o.read_valid = 1'b1;
                    o.read_byte = r.received_byte;
                end
                if (cur_phase == irrs_pkg::PH_RECV && bytes_left == 8'd0) begin
                    o.read_last = 1'b1;
                    o.issue_stop = 1'b1;
                    cur_phase = irrs_pkg::PH_IDLE;
                end else begin
                    bytes_left = bytes_left - 8'd1;
                    o.issue_receive = 1'b1;
                    o.ack_receive = (bytes_left != 8'd0);
                    cur_phase = irrs_pkg::PH_RECV;
                end
            end
            default: cur_phase = irrs_pkg::PH_IDLE;
        endcase
        return o;
    endfunction

    function automatic irrs_pkg::t_req start_req(input logic [7:0] reg_addr,
                                                 input logic [7:0] count,
                                                 input logic [7:0] status,
                                                 input logic [7:0] rx);
        irrs_pkg::t_req r;
        r.mode = irrs_pkg::MODE_START;
        r.register_address = reg_addr;
        r.byte_count = count;
        r.bus_status = status;
        r.received_byte = rx;
        return r;
    endfunction

    function automatic irrs_pkg::t_req event_req(input logic [7:0] status,
                                                 input logic [7:0] rx,
                                                 input logic [7:0] reg_addr,
                                                 input logic [7:0] count);
        irrs_pkg::t_req r;
        r = start_req(reg_addr, count, status, rx);
        r.mode = irrs_pkg::MODE_EVENT;
        return r;
    endfunction

    function automatic irrs_pkg::t_rsp rsp_of(input logic start, input logic stop,
                                              input logic [2:0] err, input logic busy);
        irrs_pkg::t_rsp o;
        o = '0;
        o.issue_start = start;
        o.issue_stop = stop;
        o.error_code = err;
        o.busy_reject = busy;
        return o;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_req(input irrs_pkg::t_req r, input bit typed,
                            input irrs_pkg::t_rsp want);
        irrs_pkg::t_rsp pred;
        while (!no_gaps && $urandom_range(99, 0) < 22) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        pred = sequencer_step(r);
        pending_responses.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic send(input irrs_pkg::t_req r);
        push_req(r, 1'b0, '0);
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_responses.size() != 0);
    endtask

    task automatic write_device_address(input logic [6:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DEV_ADDR_OFFSET;
        pwdata <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dev_addr = value;
        @(negedge i_clk);
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(dev_addr)) begin
            report_mismatch("prdata", prdata, DATA_W'(dev_addr));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, 32'(got), 32'(want));
        end
    endtask

    always @(posedge i_clk) begin
        irrs_pkg::t_rsp want;
        irrs_pkg::t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(got), 32'd0);
            end else begin
                want = pending_responses.pop_front();
                check_field("issue_start", 8'(got.issue_start), 8'(want.issue_start));
                check_field("issue_stop", 8'(got.issue_stop), 8'(want.issue_stop));
                check_field("issue_receive", 8'(got.issue_receive), 8'(want.issue_receive));
                check_field("ack_receive", 8'(got.ack_receive), 8'(want.ack_receive));
                check_field("send_valid", 8'(got.send_valid), 8'(want.send_valid));
                check_field("send_byte", got.send_byte, want.send_byte);
                check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
                check_field("read_byte", got.read_byte, want.read_byte);
                check_field("read_last", 8'(got.read_last), 8'(want.read_last));
                check_field("error_code", 8'(got.error_code), 8'(want.error_code));
                check_field("busy_reject", 8'(got.busy_reject), 8'(want.busy_reject));
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= no_gaps || ($urandom_range(99, 0) >= 22);
    end

    function automatic irrs_pkg::t_req random_start();
        return start_req(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endfunction

    task automatic maybe_busy_start();
        if ($urandom_range(99, 0) < 4) begin
            send(random_start());
        end
    endtask

    // one burst read; fail_at names the phase whose status is corrupted, idle for none
    task automatic run_burst(input logic [7:0] count, input irrs_pkg::t_phase fail_at);
        logic [7:0] status;
        logic [7:0] want;
        int unsigned n;
        if ($urandom_range(99, 0) < 10) begin
            send(event_req(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
        end
        send(start_req(rand_byte(), count, rand_byte(), rand_byte()));
        items_sent++;
        for (int p = int'(irrs_pkg::PH_START); p <= int'(irrs_pkg::PH_ADDRR); p++) begin
            maybe_busy_start();
            want = phase_status(irrs_pkg::t_phase'(p));
            if (irrs_pkg::t_phase'(p) == fail_at) begin
                do status = rand_byte(); while ((status & irrs_pkg::ST_MASK) == want);
            end else begin
                status = want | 8'($urandom_range(7, 0));
            end
            send(event_req(status, rand_byte(), rand_byte(), rand_byte()));
            items_sent++;
            if (irrs_pkg::t_phase'(p) == fail_at) begin
                return;
            end
        end
        n = (count == 8'd0) ? 1 : int'(count);
        for (int i = 0; i < n; i++) begin
            maybe_busy_start();
            send(event_req(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
            items_sent++;
        end
    endtask

    function automatic logic [7:0] random_count();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 8) return 8'd0;
        if (pick < 10) return 8'd255;
        if (pick < 13) return 8'($urandom_range(255, 1));
        return 8'($urandom_range(6, 1));
    endfunction

    function automatic irrs_pkg::t_phase random_fail();
        if ($urandom_range(99, 0) < 25) begin
            return irrs_pkg::t_phase'($urandom_range(int'(irrs_pkg::PH_ADDRR),
                                                     int'(irrs_pkg::PH_START)));
        end
        return irrs_pkg::PH_IDLE;
    endfunction

    initial begin
        t_row rows[$];
        logic [6:0] settings[5];

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        no_gaps = 1'b0;
        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        cur_phase = irrs_pkg::PH_IDLE;
        first_reg = 8'd0;
        bytes_left = 8'd0;
        dev_addr = irrs_pkg::DEV_ADDR_RESET;

        // completion while idle, zero count, busy start, full read with status low bits set
        rows.push_back('{event_req(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, '0});
        rows.push_back('{start_req(8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b1, 1'b0, irrs_pkg::ERR_NONE, 1'b0)});
        rows.push_back('{start_req(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                         rsp_of(1'b0, 1'b0, irrs_pkg::ERR_NONE, 1'b1)});
        rows.push_back('{event_req(8'h0F, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h1F, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h2F, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h17, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h47, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'hFF, 8'hFF, 8'h00, 8'h00), 1'b0, '0});
        // bad start status
        rows.push_back('{start_req(8'hAA, 8'h02, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b1, 1'b0, irrs_pkg::ERR_NONE, 1'b0)});
        rows.push_back('{event_req(8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b0, 1'b1, irrs_pkg::ERR_START, 1'b0)});
        // nack on read address
        rows.push_back('{start_req(8'h3C, 8'h01, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b1, 1'b0, irrs_pkg::ERR_NONE, 1'b0)});
        rows.push_back('{event_req(irrs_pkg::ST_START, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_SLA_W_ACK, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_DATA_W_ACK, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_REP_START, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h48, 8'h00, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b0, 1'b1, irrs_pkg::ERR_ADDR_R, 1'b0)});
        // two-byte read
        rows.push_back('{start_req(8'h55, 8'h02, 8'h00, 8'h00), 1'b1,
                         rsp_of(1'b1, 1'b0, irrs_pkg::ERR_NONE, 1'b0)});
        rows.push_back('{event_req(irrs_pkg::ST_START, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_SLA_W_ACK, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_DATA_W_ACK, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_REP_START, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(irrs_pkg::ST_SLA_R_ACK, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h00, 8'h00, 8'h00, 8'h00), 1'b0, '0});
        rows.push_back('{event_req(8'h3E, 8'h5A, 8'h00, 8'h00), 1'b0, '0});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            push_req(rows[i].req, rows[i].typed, rows[i].want);
        end
        drain_responses();

        settings[0] = 7'h7F;
        settings[1] = 7'h00;
        settings[2] = 7'($urandom_range(126, 1));
        settings[3] = 7'h55;
        settings[4] = 7'($urandom_range(127, 0));

        foreach (settings[s]) begin
            write_device_address(settings[s]);
            no_gaps = (s == 2);
            items_sent = 0;
            if (s == 0) begin
                run_burst(8'd255, irrs_pkg::PH_IDLE);
            end
            while (items_sent < SEGMENT_ITEMS) begin
                run_burst(random_count(), random_fail());
            end
            drain_responses();
        end
        no_gaps = 1'b0;

        repeat (8) @(negedge i_clk);
        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
